[hw/rtl/point_in_polygon_ray_cast_top_macros.svh]
// ----------------------------------------------------------------------------
// point-in-polygon assertion macros
// concurrent check wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_RAY_CAST_TOP_MACROS_SVH
`define POINT_IN_POLYGON_RAY_CAST_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PIPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PIPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PIPR_ASSERT_IMP(lbl, ante, cons, msg)
`define PIPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/pipr_pkg.sv]
// ----------------------------------------------------------------------------
// pipr_pkg
// shared types and constants of the point-in-polygon block
// ----------------------------------------------------------------------------
package pipr_pkg;

	localparam int MARGIN_W = 16;
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd128;

	// item kind codes
	localparam logic KIND_POINT  = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	// control part of one edge job
	typedef struct packed {
		logic start;   // first vertex of a polygon, parity restarts
		logic edge_a;  // edge from previous vertex to this one is live
		logic last;    // closing edge live, result emitted
	} pipr_ctl_t;

	// back-end status seen by the top level
	typedef struct packed {
		logic s2_valid;
		logic s2_last;
		logic advance;
	} pipr_bst_t;

endpackage

[hw/rtl/pipr_queue.sv]
// ----------------------------------------------------------------------------
// pipr_queue
// small register fifo between front and back end
// ----------------------------------------------------------------------------
module pipr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/pipr_front.sv]
// ----------------------------------------------------------------------------
// pipr_front
// accepts points and vertices, tracks polygon context, issues edge jobs
// ----------------------------------------------------------------------------
module pipr_front #(
	parameter int W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [W-1:0]        coord_x,
	input  logic [W-1:0]        coord_y,
	input  logic                last_vertex,
	input  logic                q_full,
	output logic                q_push,
	output pipr_pkg::pipr_ctl_t job_ctl,
	output logic [W-1:0]        job_tx,
	output logic [W-1:0]        job_ty,
	output logic [W-1:0]        job_px,
	output logic [W-1:0]        job_py,
	output logic [W-1:0]        job_cx,
	output logic [W-1:0]        job_cy,
	output logic [W-1:0]        job_fx,
	output logic [W-1:0]        job_fy
);
	import pipr_pkg::*;

	logic [W-1:0] test_x_q;
	logic [W-1:0] test_y_q;
	logic [W-1:0] first_x_q;
	logic [W-1:0] first_y_q;
	logic [W-1:0] prev_x_q;
	logic [W-1:0] prev_y_q;
	logic         have_first_q;
	logic         accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (kind == KIND_VERTEX);

	always_comb begin
		job_ctl.start  = !have_first_q;
		job_ctl.edge_a = have_first_q;
		job_ctl.last   = last_vertex;
		job_tx = test_x_q;
		job_ty = test_y_q;
		job_px = prev_x_q;
		job_py = prev_y_q;
		job_cx = coord_x;
		job_cy = coord_y;
		// a one-vertex polygon closes onto itself
		job_fx = have_first_q ? first_x_q : coord_x;
		job_fy = have_first_q ? first_y_q : coord_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_x_q     <= '0;
			test_y_q     <= '0;
			have_first_q <= 1'b0;
		end else if (accept) begin
			if (kind == KIND_POINT) begin
				test_x_q     <= coord_x;
				test_y_q     <= coord_y;
				have_first_q <= 1'b0;
			end else begin
				have_first_q <= !last_vertex;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			prev_x_q <= coord_x;
			prev_y_q <= coord_y;
			if (!have_first_q) begin
				first_x_q <= coord_x;
				first_y_q <= coord_y;
			end
		end
	end

endmodule

[hw/rtl/pipr_back.sv]
// ----------------------------------------------------------------------------
// pipr_back
// edge tests: differences, cross products, compare and parity
// ----------------------------------------------------------------------------
module pipr_back #(
	parameter int W = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  pipr_pkg::pipr_ctl_t            job_ctl,
	input  logic [W-1:0]                   job_tx,
	input  logic [W-1:0]                   job_ty,
	input  logic [W-1:0]                   job_px,
	input  logic [W-1:0]                   job_py,
	input  logic [W-1:0]                   job_cx,
	input  logic [W-1:0]                   job_cy,
	input  logic [W-1:0]                   job_fx,
	input  logic [W-1:0]                   job_fy,
	input  logic [pipr_pkg::MARGIN_W-1:0]  margin,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           inside_res,
	output pipr_pkg::pipr_bst_t            bst
);
	import pipr_pkg::*;

	// test point with margin, then one more bit for the x difference
	localparam int EW = ((W > MARGIN_W) ? W : MARGIN_W) + 2;
	localparam int DW = EW + 1;
	localparam int FW = W + 1;
	localparam int PW = DW + FW;

	logic signed [W-1:0]  xa [2];
	logic signed [W-1:0]  ya [2];
	logic signed [W-1:0]  xb [2];
	logic signed [W-1:0]  yb [2];
	logic                 live [2];
	logic signed [EW-1:0] ty_m;
	logic signed [EW-1:0] tx_m;
	logic                 advance;
	logic                 toggle [2];
	logic                 par_base;
	logic                 par_next;

	logic signed [DW-1:0] dtx_s1 [2];
	logic signed [FW-1:0] dy_s1 [2];
	logic signed [FW-1:0] dxb_s1 [2];
	logic signed [FW-1:0] dty_s1 [2];
	logic                 ten_s1 [2];
	logic                 start_s1;
	logic                 last_s1;
	logic                 v_s1;

	logic signed [PW-1:0] lhs_s2 [2];
	logic signed [PW-1:0] rhs_s2 [2];
	logic                 dyneg_s2 [2];
	logic                 ten_s2 [2];
	logic                 start_s2;
	logic                 last_s2;
	logic                 v_s2;

	logic                 parity_q;
	logic                 out_valid_q;
	logic                 inside_res_q;

	assign advance    = !(out_valid_q && out_stall);
	assign q_pop      = advance && !q_empty;
	assign out_valid  = out_valid_q;
	assign inside_res = inside_res_q;

	assign bst.s2_valid = v_s2;
	assign bst.s2_last  = last_s2;
	assign bst.advance  = advance;

	// edge 0: previous to current vertex, edge 1: current back to first
	always_comb begin
		xa[0] = job_px;
		ya[0] = job_py;
		xb[0] = job_cx;
		yb[0] = job_cy;
		live[0] = job_ctl.edge_a;
		xa[1] = job_cx;
		ya[1] = job_cy;
		xb[1] = job_fx;
		yb[1] = job_fy;
		live[1] = job_ctl.last;
		ty_m = EW'(signed'(job_ty)) + signed'(EW'(margin));
		tx_m = EW'(signed'(job_tx)) - signed'(EW'(margin));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int e = 0; e < 2; e++) begin
				dtx_s1[e] <= DW'(tx_m) - DW'(xa[e]);
				dy_s1[e]  <= FW'(yb[e]) - FW'(ya[e]);
				dxb_s1[e] <= FW'(xb[e]) - FW'(xa[e]);
				dty_s1[e] <= FW'(signed'(job_ty)) - FW'(ya[e]);
				ten_s1[e] <= live[e] && ((EW'(ya[e]) < ty_m) != (EW'(yb[e]) < ty_m));
			end
			start_s1 <= job_ctl.start;
			last_s1  <= job_ctl.last;

			for (int e = 0; e < 2; e++) begin
				lhs_s2[e]   <= PW'(dtx_s1[e]) * PW'(dy_s1[e]);
				rhs_s2[e]   <= PW'(dxb_s1[e]) * PW'(dty_s1[e]);
				dyneg_s2[e] <= dy_s1[e][FW-1];
				ten_s2[e]   <= ten_s1[e];
			end
			start_s2 <= start_s1;
			last_s2  <= last_s1;
		end
	end

	// division-free crossing test, direction flips with the sign of dy
	always_comb begin
		for (int e = 0; e < 2; e++) begin
			toggle[e] = ten_s2[e] &&
				(dyneg_s2[e] ? (rhs_s2[e] < lhs_s2[e]) : (lhs_s2[e] < rhs_s2[e]));
		end
		par_base = start_s2 ? 1'b0 : parity_q;
		par_next = par_base ^ toggle[0] ^ toggle[1];
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2 && last_s2) begin
			inside_res_q <= par_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			out_valid_q <= v_s2 && last_s2;
			if (v_s2) begin
				parity_q <= last_s2 ? 1'b0 : par_next;
			end
		end
	end

endmodule

[hw/rtl/point_in_polygon_ray_cast_top.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast_top
// crossing-number point-in-polygon test with a margin, streaming vertices
// ----------------------------------------------------------------------------
// A point transaction (kind 0) loads the test point; vertex transactions
// (kind 1) follow, one edge test per vertex, and the vertex flagged
// last_vertex also tests the closing edge and produces one inside_res
// transaction (1 = odd crossing count). The test point stays loaded, so
// further polygons may follow for the same point. One item is accepted per
// clock while in_stall is low; a closing job passes through the queue, stage
// one, stage two and the result register before its result appears. The back
// end has two pairs of signed cross-product multipliers, one pair per edge, each
// registered. A queue of QUEUE_DEPTH jobs sits between the front end and
// the back end, so in_stall rises only once out_stall has backed up the
// pipeline and filled the queue. margin is written through cfg_valid and
// cfg_ready (always ready) and must only change while the block is idle;
// it resets to 128 (0.5 in Q.8).
`include "point_in_polygon_ray_cast_top_macros.svh"

module point_in_polygon_ray_cast_top #(
	parameter int COORD_WIDTH = 24,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic                          last_vertex,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          inside_res,
	// margin register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pipr_pkg::MARGIN_W-1:0] margin
);
	import pipr_pkg::*;

	localparam int CTL_W = $bits(pipr_ctl_t);
	localparam int JOB_W = CTL_W + 8 * COORD_WIDTH;

	logic [MARGIN_W-1:0]    margin_q;
	logic                   q_push;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [JOB_W-1:0]       q_wdata;
	logic [JOB_W-1:0]       q_rdata;
	pipr_ctl_t              f_ctl;
	pipr_ctl_t              b_ctl;
	logic [COORD_WIDTH-1:0] f_tx, f_ty, f_px, f_py, f_cx, f_cy, f_fx, f_fy;
	logic [COORD_WIDTH-1:0] b_tx, b_ty, b_px, b_py, b_cx, b_cy, b_fx, b_fy;
	pipr_bst_t              bst;

	// configuration: single register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= MARGIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			margin_q <= margin;
		end
	end

	// front end: polygon context and job issue
	pipr_front #(
		.W (COORD_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.last_vertex (last_vertex),
		.q_full      (q_full),
		.q_push      (q_push),
		.job_ctl     (f_ctl),
		.job_tx      (f_tx),
		.job_ty      (f_ty),
		.job_px      (f_px),
		.job_py      (f_py),
		.job_cx      (f_cx),
		.job_cy      (f_cy),
		.job_fx      (f_fx),
		.job_fy      (f_fy)
	);

	assign q_wdata = {f_ctl, f_tx, f_ty, f_px, f_py, f_cx, f_cy, f_fx, f_fy};

	// job queue decoupling the two halves
	pipr_queue #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	assign {b_ctl, b_tx, b_ty, b_px, b_py, b_cx, b_cy, b_fx, b_fy} = q_rdata;

	// back end: edge arithmetic, parity and result register
	pipr_back #(
		.W (COORD_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.job_ctl    (b_ctl),
		.job_tx     (b_tx),
		.job_ty     (b_ty),
		.job_px     (b_px),
		.job_py     (b_py),
		.job_cx     (b_cx),
		.job_cy     (b_cy),
		.job_fx     (b_fx),
		.job_fy     (b_fy),
		.margin     (margin_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res),
		.bst        (bst)
	);

	// a new result only ever comes from a closing job leaving stage two
	`PIPR_ASSERT_IMP(a_result_source, $rose(out_valid),
		$past(bst.s2_valid && bst.s2_last && bst.advance), "result without closing job")

	// a closing job that moves on always lands in the result register
	`PIPR_ASSERT_NEXT(a_result_issued, bst.s2_valid && bst.s2_last && bst.advance,
		out_valid, "closing job lost")

	// a held result freezes the back-end pipeline
	`PIPR_ASSERT_IMP(a_back_frozen, out_valid && out_stall,
		!bst.advance && !q_pop, "back end moved under a held result")

endmodule

[tb/tb_point_in_polygon_ray_cast_top.sv]
// ----------------------------------------------------------------------------
// point-in-polygon block testbench
// streams points and polygons through the block, predicts each inside flag
// and checks every result transaction against the oldest prediction
// ----------------------------------------------------------------------------

// keeps its own copy of the test point, the polygon walk and the margin, and
// queues the inside flag that each closing vertex must produce
class inside_scoreboard #(int CW = 24);
	logic [pipr_pkg::MARGIN_W-1:0] margin_q;
	longint pt_x, pt_y, first_x, first_y, prev_x, prev_y;
	bit have_first, parity;
	bit inside_q[$];
	int errors;
	int n_checked;

	function new();
		margin_q = pipr_pkg::MARGIN_RESET;
		pt_x = 0;
		pt_y = 0;
		first_x = 0;
		first_y = 0;
		prev_x = 0;
		prev_y = 0;
		have_first = 0;
		parity = 0;
		errors = 0;
		n_checked = 0;
	endfunction

	// edge a->b flips parity when it straddles y+margin and x-margin lies left
	// of its crossing at the unshifted y, compared by cross-multiplication
	function bit edge_toggles(longint xa, longint ya, longint xb, longint yb);
		longint ty, tx, dy, lhs, rhs;
		ty = pt_y + longint'(margin_q);
		if ((ya < ty) == (yb < ty))
			return 0;
		dy = yb - ya;
		tx = pt_x - longint'(margin_q);
		lhs = (tx - xa) * dy;
		rhs = (xb - xa) * (pt_y - ya);
		return (dy > 0) ? (lhs < rhs) : (rhs < lhs);
	endfunction

	function void note_item(logic k, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic last);
		longint vx, vy;
		vx = x;
		vy = y;
		if (k == pipr_pkg::KIND_POINT) begin
			pt_x = vx;
			pt_y = vy;
			parity = 0;
			have_first = 0;
			return;
		end
		if (!have_first) begin
			first_x = vx;
			first_y = vy;
			have_first = 1;
		end else begin
			parity ^= edge_toggles(prev_x, prev_y, vx, vy);
		end
		prev_x = vx;
		prev_y = vy;
		if (last) begin
			parity ^= edge_toggles(vx, vy, first_x, first_y);
			inside_q.insert(inside_q.size(), parity);
			parity = 0;
			have_first = 0;
		end
	endfunction

	task report(string what);
		errors++;
		if (errors <= 30)
			$display("mismatch: %s", what);
	endtask

	task check_result(logic got);
		bit want;
		if (inside_q.size() == 0) begin
			report($sformatf("inside_res %0b with no polygon closed", got));
			return;
		end
		want = inside_q.pop_front();
		if (got !== want)
			report($sformatf("inside_res %0b, predicted %0b (result %0d)", got, want,
				n_checked));
		n_checked++;
	endtask
endclass

module tb_point_in_polygon_ray_cast_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pipr_pkg::*;

	localparam int CW = 24;
	localparam longint CMIN = -(longint'(1) << (CW - 1));
	localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
	localparam int HOLD_CYCLES = 400;      // long receiver hold-off, fills the job queue
	localparam int SETTLE_CYCLES = 16;     // covers the back-end pipe after the last result
	localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is abandoned
	localparam int ITEMS_PER_PHASE = 245;
	localparam int N_PHASES = 6;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = KIND_POINT;
	logic signed [CW-1:0] coord_x = '0;
	logic signed [CW-1:0] coord_y = '0;
	logic last_vertex = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic inside_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [MARGIN_W-1:0] margin = MARGIN_RESET;

	inside_scoreboard #(CW) sb;

	// per-phase behaviour of the two sides
	bit snd_idle = 1'b1;
	bit rcv_idle = 1'b1;
	bit hold_req = 1'b0;

	// generator view of the current test point and margin
	longint cur_px = 0;
	longint cur_py = 0;
	longint cur_margin = MARGIN_RESET;
	int items_sent = 0;
	int quiet_cycles = 0;

	point_in_polygon_ray_cast_top #(.COORD_WIDTH(CW)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.last_vertex(last_vertex),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.margin     (margin)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// both channels sampled at the edge, before any of this step's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_item(kind, coord_x, coord_y, last_vertex);
			if (out_valid && !out_stall)
				sb.check_result(inside_res);
		end
	end

	// watchdog: any transaction on any channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("point_in_polygon_ray_cast_top regression: fail");
			$finish;
		end
	end

	// result side: a random hold-off before each result while rcv_idle is set, or the long one on request
	initial begin : receiver
		int hold;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold = HOLD_CYCLES;
			end else begin
				hold = rcv_idle ? $urandom_range(0, 19) : 0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// fold a value into the signed coordinate range
	function automatic longint wrap(longint v);
		logic signed [CW-1:0] t;
		t = v[CW-1:0];
		return t;
	endfunction

	// mostly near the centre at one of several scales, sometimes anywhere or at an extreme
	function automatic longint pick_coord(longint centre);
		longint spread;
		case ($urandom_range(0, 9))
			0: return wrap(longint'($urandom));
			1: return $urandom_range(0, 1) ? CMAX : CMIN;
			default: begin
				spread = longint'(1) << (4 * $urandom_range(2, 5));
				return wrap(centre + longint'($urandom_range(0, 32'(2 * spread))) - spread);
			end
		endcase
	endfunction

	// one input transaction; valid stays up if the next item follows with no gap
	task automatic send_item(logic k, longint x, longint y, logic last);
		int gap;
		gap = snd_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		coord_x <= x[CW-1:0];
		coord_y <= y[CW-1:0];
		last_vertex <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (k == KIND_POINT) begin
			cur_px = wrap(x);
			cur_py = wrap(y);
		end
	endtask

	// sender stops and waits until every predicted flag has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.inside_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_margin(logic [MARGIN_W-1:0] v);
		margin <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.margin_q = v;
		cur_margin = v;
	endtask

	// vertices around the current point, with boundary y values and flat edges mixed in;
	// now and then the polygon is cut short by a fresh point
	task automatic send_polygon(int nv);
		longint x, y, py;
		py = cur_py;
		for (int i = 0; i < nv; i++) begin
			if (i > 0 && $urandom_range(0, 19) == 0) begin
				send_item(KIND_POINT, pick_coord(0), pick_coord(0), 1'($urandom_range(0, 1)));
				return;
			end
			x = pick_coord(cur_px);
			case ($urandom_range(0, 9))
				0: y = wrap(cur_py + cur_margin - $urandom_range(0, 1));
				1: y = py;
				default: y = pick_coord(cur_py);
			endcase
			send_item(KIND_VERTEX, x, y, i == nv - 1);
			py = y;
		end
	endtask

	task automatic random_phase(int target);
		int nv;
		while (items_sent < target) begin
			if ($urandom_range(0, 19) == 0) begin
				// stray transaction with arbitrary fields
				send_item(1'($urandom_range(0, 1)), wrap(longint'($urandom)),
					wrap(longint'($urandom)), 1'($urandom_range(0, 1)));
			end else begin
				send_item(KIND_POINT, pick_coord(0), pick_coord(0), 1'($urandom_range(0, 1)));
				repeat ($urandom_range(1, 3)) begin
					nv = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 24)
						: $urandom_range(1, 8);
					send_polygon(nv);
				end
			end
		end
	endtask

	initial begin : stimulus
		logic [MARGIN_W-1:0] m;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, margin still at its reset value
		// vertices before any point: the test point is the reset origin
		send_item(KIND_VERTEX, -1000, -1000, 1'b0);
		send_item(KIND_VERTEX, 1000, -1000, 1'b0);
		send_item(KIND_VERTEX, 0, 1000, 1'b1);
		// last_vertex on a point transaction is ignored
		send_item(KIND_POINT, 0, 0, 1'b1);
		// square with flat top and bottom edges
		send_item(KIND_VERTEX, -512, -512, 1'b0);
		send_item(KIND_VERTEX, 512, -512, 1'b0);
		send_item(KIND_VERTEX, 512, 512, 1'b0);
		send_item(KIND_VERTEX, -512, 512, 1'b1);
		// same point kept, one-vertex polygon closes on itself
		send_item(KIND_VERTEX, 5, 5, 1'b1);
		// coordinate extremes on point and vertices
		send_item(KIND_POINT, CMAX, CMIN, 1'b0);
		send_item(KIND_VERTEX, CMIN, CMIN, 1'b0);
		send_item(KIND_VERTEX, CMAX, CMIN, 1'b0);
		send_item(KIND_VERTEX, CMAX, CMAX, 1'b0);
		send_item(KIND_VERTEX, CMIN, CMAX, 1'b1);
		send_item(KIND_POINT, CMIN, CMAX, 1'b0);
		send_item(KIND_VERTEX, CMIN, CMIN, 1'b0);
		send_item(KIND_VERTEX, CMAX, CMIN, 1'b0);
		send_item(KIND_VERTEX, CMAX, CMAX, 1'b0);
		send_item(KIND_VERTEX, CMIN, CMAX, 1'b1);
		// vertices sitting on and just under the shifted test y
		send_item(KIND_POINT, 0, 0, 1'b0);
		send_item(KIND_VERTEX, 256, 128, 1'b0);
		send_item(KIND_VERTEX, 256, -512, 1'b0);
		send_item(KIND_VERTEX, -256, 127, 1'b1);
		settle();

		// random phases, each under its own margin and idling pattern
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin m = '0; snd_idle = 1'b1; rcv_idle = 1'b1; end
				1: begin m = '1; snd_idle = 1'b0; rcv_idle = 1'b0; end
				2: begin
					// back-pressure: receiver holds off while the sender streams flat out
					m = MARGIN_W'($urandom);
					snd_idle = 1'b0;
					rcv_idle = 1'b1;
					hold_req = 1'b1;
				end
				3: begin m = 16'd1; snd_idle = 1'b1; rcv_idle = 1'b0; end
				default: begin
					m = MARGIN_W'($urandom);
					snd_idle = 1'($urandom_range(0, 1));
					rcv_idle = 1'($urandom_range(0, 1));
				end
			endcase
			write_margin(m);
			random_phase(items_sent + ITEMS_PER_PHASE);
			settle();
		end

		if (sb.errors == 0)
			$display("point_in_polygon_ray_cast_top regression: pass");
		else
			$display("point_in_polygon_ray_cast_top regression: fail");
		$finish;
	end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pipr_pkg.sv
hw/rtl/pipr_queue.sv
hw/rtl/pipr_front.sv
hw/rtl/pipr_back.sv
hw/rtl/point_in_polygon_ray_cast_top.sv
tb/tb_point_in_polygon_ray_cast_top.sv
